### design/ricache_pkg.sv
// Package: types, codes and sizes shared by the inode cache table.
package ricache_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
    localparam int NUM_HANDLES = 16;
    localparam int LIVE_BITS   = $clog2(NUM_HANDLES);
    localparam int REF_BITS    = 16;

    localparam logic [4:0]          HANDLE_MAX = 5'(NUM_HANDLES);
    localparam logic [REF_BITS-1:0] REF_MAX    = {REF_BITS{1'b1}};

    // Operation codes
    typedef enum logic [2:0] {
        K_LOOKUP  = 3'd0,
        K_INSERT  = 3'd1,
        K_RELEASE = 3'd2,
        K_CLEAR   = 3'd3,
        K_CREATE  = 3'd4
    } t_kind;

    // Result status codes
    typedef enum logic [3:0] {
        ST_FOUND       = 4'd0,
        ST_INSERTED    = 4'd1,
        ST_NOT_FOUND   = 4'd2,
        ST_BAD_HANDLE  = 4'd3,
        ST_TABLE_FULL  = 4'd4,
        ST_RELEASED    = 4'd5,
        ST_FREED       = 4'd6,
        ST_CLEARED     = 4'd7,
        ST_HANDLE_MADE = 4'd8,
        ST_NO_HANDLES  = 4'd9
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Request word
    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  handle;
        logic [63:0] inode_key;
        logic [63:0] node_payload;
        logic [15:0] init_refs;
    } t_req;

    // Result word
    typedef struct packed {
        t_status     status;
        logic [5:0]  slot;
        logic [15:0] ref_count;
        logic [63:0] payload_out;
        logic [6:0]  freed_count;
        logic [4:0]  new_handle;
    } t_rsp;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [4:0]          owner;
        logic [63:0]         key;
        logic [REF_BITS-1:0] refs;
        logic [63:0]         data;
    } t_entry;

endpackage

### design/refcounted_inode_cache_table.sv
// Top level: reference-counted inode cache table with a sequential slot scanner.
//
// Usage: a request word enters on i_in_valid/o_in_ready, a result word leaves on
// o_out_valid/i_out_ready; each word moves when valid and ready are both high.
// Lookup, insert, release and clear on a live handle scan all 64 slots of the
// table memory, one slot a cycle through its single registered read port; each
// slot read back is compared, and a final step then applies the update and
// loads the result. Create, and any request on a bad handle, skips the scan and
// goes straight to the final step. Kinds five to seven are accepted and give no
// result.
// One request is in work at a time; o_in_ready is high only while the sequencer
// idles, so a new request cannot be accepted while a scan is in work.
// The result sits in an output register; a stalled receiver holds the
// block in its final step until that register is taken, and a new request can
// be accepted as soon as the result is loaded.
// Reset clears all entry valid bits, retires all handles and sets the next
// handle to one; the slot memory itself is not cleared and needs no sweep.
module refcounted_inode_cache_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ricache_pkg::t_req   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ricache_pkg::t_rsp   o_out
);
    import ricache_pkg::*;

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_out;
    logic   r_out_vld;

    logic [TABLE_DEPTH-1:0] r_entry_valid;
    logic [NUM_HANDLES-1:0] r_live;
    logic [4:0]             r_next_handle;

    // Scan counter and compare stage
    logic [SLOT_BITS:0]   r_cnt;
    logic                 r_cmp_vld;
    logic [SLOT_BITS-1:0] r_cmp_idx;

    // Scan findings
    logic                 r_hit;
    logic [SLOT_BITS-1:0] r_hit_slot;
    logic [REF_BITS-1:0]  r_hit_refs;
    logic [63:0]          r_hit_data;
    logic                 r_free;
    logic [SLOT_BITS-1:0] r_free_slot;
    logic [6:0]           r_freed_cnt;

    // Slot memory
    t_entry mem [TABLE_DEPTH];
    t_entry r_rd_data;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_fire;
    logic                 w_in_ok;
    logic                 w_req_ok;
    logic [LIVE_BITS-1:0] w_in_hidx;
    logic [LIVE_BITS-1:0] w_req_hidx;
    logic [LIVE_BITS-1:0] w_new_hidx;
    logic                 w_own;
    logic                 w_key_eq;

    // Update controls from the final step
    logic                 w_we;
    logic [SLOT_BITS-1:0] w_waddr;
    t_entry               w_wdata;
    logic                 w_set_valid;
    logic                 w_clr_valid;
    logic [SLOT_BITS-1:0] w_vslot;
    logic                 w_set_live;
    logic                 w_clr_live;
    t_rsp                 w_rsp;
    logic [REF_BITS-1:0]  w_inc_refs;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_fire     = (r_state == S_DONE) && w_out_free;

    // Handle checks on the incoming and the held request
    assign w_in_hidx  = LIVE_BITS'(i_in.handle - 5'd1);
    assign w_req_hidx = LIVE_BITS'(r_req.handle - 5'd1);
    assign w_new_hidx = LIVE_BITS'(r_next_handle - 5'd1);
    assign w_in_ok    = (i_in.handle != 5'd0) && (i_in.handle <= HANDLE_MAX)
                        && r_live[w_in_hidx];
    assign w_req_ok   = (r_req.handle != 5'd0) && (r_req.handle <= HANDLE_MAX)
                        && r_live[w_req_hidx];

    // Compare the slot read back last cycle
    assign w_own    = r_entry_valid[r_cmp_idx] && (r_rd_data.owner == r_req.handle);
    assign w_key_eq = (r_rd_data.key == r_req.inode_key);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.kind > K_CREATE) begin
                        n_state = S_IDLE;
                    end else if (i_in.kind == K_CREATE || !w_in_ok) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cmp_vld && (r_cmp_idx == SLOT_BITS'(TABLE_DEPTH - 1))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_inc_refs = (r_hit_refs == REF_MAX) ? r_hit_refs : r_hit_refs + 1'b1;

    // Final step: result word and table updates
    always_comb begin
        w_rsp       = '0;
        w_rsp.status = ST_NOT_FOUND;
        w_we        = 1'b0;
        w_waddr     = r_hit_slot;
        w_wdata     = '{owner: r_req.handle, key: r_req.inode_key,
                        refs: r_hit_refs, data: r_hit_data};
        w_set_valid = 1'b0;
        w_clr_valid = 1'b0;
        w_vslot     = r_hit_slot;
        w_set_live  = 1'b0;
        w_clr_live  = 1'b0;
        if (r_req.kind == K_CREATE) begin
            if (r_next_handle > HANDLE_MAX) begin
                w_rsp.status = ST_NO_HANDLES;
            end else begin
                w_rsp.status     = ST_HANDLE_MADE;
                w_rsp.new_handle = r_next_handle;
                w_set_live       = 1'b1;
            end
        end else if (!w_req_ok) begin
            w_rsp.status = ST_BAD_HANDLE;
        end else begin
            case (r_req.kind)
                K_CLEAR: begin
                    w_rsp.status      = ST_CLEARED;
                    w_rsp.freed_count = r_freed_cnt;
                    w_clr_live        = 1'b1;
                end
                K_LOOKUP, K_INSERT: begin
                    if (r_hit) begin
                        w_rsp.status      = ST_FOUND;
                        w_rsp.slot        = 6'(r_hit_slot);
                        w_rsp.ref_count   = 16'(w_inc_refs);
                        w_rsp.payload_out = r_hit_data;
                        w_we              = 1'b1;
                        w_wdata.refs      = w_inc_refs;
                    end else if (r_req.kind == K_LOOKUP) begin
                        w_rsp.status = ST_NOT_FOUND;
                    end else if (!r_free) begin
                        w_rsp.status = ST_TABLE_FULL;
                    end else begin
                        w_rsp.status      = ST_INSERTED;
                        w_rsp.slot        = 6'(r_free_slot);
                        w_rsp.ref_count   = r_req.init_refs;
                        w_rsp.payload_out = r_req.node_payload;
                        w_we              = 1'b1;
                        w_waddr           = r_free_slot;
                        w_wdata.refs      = REF_BITS'(r_req.init_refs);
                        w_wdata.data      = r_req.node_payload;
                        w_set_valid       = 1'b1;
                        w_vslot           = r_free_slot;
                    end
                end
                K_RELEASE: begin
                    if (!r_hit) begin
                        w_rsp.status = ST_NOT_FOUND;
                    end else if (r_hit_refs <= REF_BITS'(1)) begin
                        w_rsp.status = ST_FREED;
                        w_rsp.slot   = 6'(r_hit_slot);
                        w_clr_valid  = 1'b1;
                    end else begin
                        w_rsp.status    = ST_RELEASED;
                        w_rsp.slot      = 6'(r_hit_slot);
                        w_rsp.ref_count = 16'(r_hit_refs - 1'b1);
                        w_we            = 1'b1;
                        w_wdata.refs    = r_hit_refs - 1'b1;
                    end
                end
                default: w_rsp.status = ST_NOT_FOUND;
            endcase
        end
    end

    // Slot memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_fire && w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_SCAN) begin
            r_rd_data <= mem[r_cnt[SLOT_BITS-1:0]];
        end
    end

    // Hold the request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in;
        end
    end

    // Advance the sequencer and the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_idx   <= '0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_freed_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_SCAN) && !r_cnt[SLOT_BITS];
            r_cmp_idx <= r_cnt[SLOT_BITS-1:0];
            if (w_accept) begin
                r_cnt       <= '0;
                r_hit       <= 1'b0;
                r_free      <= 1'b0;
                r_freed_cnt <= '0;
            end else if (r_state == S_SCAN) begin
                if (!r_cnt[SLOT_BITS]) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (r_cmp_vld) begin
                    if (r_req.kind == K_CLEAR && w_own) begin
                        r_freed_cnt <= r_freed_cnt + 7'd1;
                    end
                    if (!r_hit && w_own && w_key_eq) begin
                        r_hit <= 1'b1;
                    end
                    if (!r_free && !r_entry_valid[r_cmp_idx]) begin
                        r_free <= 1'b1;
                    end
                end
            end
        end
    end

    // Capture the first match and first free slot
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_cmp_vld) begin
            if (!r_hit && w_own && w_key_eq) begin
                r_hit_slot <= r_cmp_idx;
                r_hit_refs <= r_rd_data.refs;
                r_hit_data <= r_rd_data.data;
            end
            if (!r_free && !r_entry_valid[r_cmp_idx]) begin
                r_free_slot <= r_cmp_idx;
            end
        end
    end

    // Entry valid bits, live handles and handle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_live        <= '0;
            r_next_handle <= 5'd1;
        end else begin
            if (r_state == S_SCAN && r_cmp_vld && r_req.kind == K_CLEAR && w_own) begin
                r_entry_valid[r_cmp_idx] <= 1'b0;
            end
            if (w_fire) begin
                if (w_set_valid) begin
                    r_entry_valid[w_vslot] <= 1'b1;
                end
                if (w_clr_valid) begin
                    r_entry_valid[w_vslot] <= 1'b0;
                end
                if (w_set_live) begin
                    r_live[w_new_hidx] <= 1'b1;
                    r_next_handle      <= r_next_handle + 5'd1;
                end
                if (w_clr_live) begin
                    r_live[w_req_hidx] <= 1'b0;
                end
            end
        end
    end

    // Output register: load on the final step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_rsp;
        end
    end

endmodule
